// ===== src/fbc_pkg.sv =====
`default_nettype none

package fbc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COEF_BITS_DEF  = 16;

    localparam int PLANES    = 6;
    localparam int AXES      = 3;
    localparam int COLS      = 4;
    localparam int ROWS      = 4;
    localparam int LANE_W    = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int W_SHIFT   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;

    localparam logic [CFG_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [CFG_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [CFG_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [CFG_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

    // Plane p uses row p/2; the top/bottom pair subtracts first.
    localparam logic [PLANES-1:0] PLANE_MINUS = 6'b10_01_10;

endpackage

`default_nettype wire

// ===== src/frustum_box_cull_top.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_volume_is_box, i_min_*, i_max_*
// out      output     o_out_valid / i_out_ready  o_visible
// cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Three register stages: input word, per-plane corner maxima, visible flag.
// One word per cycle unless the output stalls; o_out_valid follows the visible stage.
// Plane coefficients are re-registered from the matrix rows every cycle.
// Synchronous active-low reset clears valid bits and loads the identity matrix.
// A stall at the output holds each full stage; empty stages still fill.

module frustum_box_cull_top #(
    parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = fbc_pkg::COEF_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fbc_pkg::CFG_W-1:0]        i_cfg_data,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_volume_is_box,
    input  wire logic signed [COORD_BITS-1:0]     i_min_x,
    input  wire logic signed [COORD_BITS-1:0]     i_min_y,
    input  wire logic signed [COORD_BITS-1:0]     i_min_z,
    input  wire logic signed [COORD_BITS-1:0]     i_max_x,
    input  wire logic signed [COORD_BITS-1:0]     i_max_y,
    input  wire logic signed [COORD_BITS-1:0]     i_max_z,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_visible
);

    localparam int CW = COEF_BITS + 1;
    localparam int PW = CW + COORD_BITS;
    localparam int SW = PW + 2;

    logic [fbc_pkg::CFG_W-1:0] r_mat [fbc_pkg::ROWS];

    logic signed [CW-1:0] r_coef [fbc_pkg::PLANES][fbc_pkg::COLS];
    logic signed [CW-1:0] n_coef [fbc_pkg::PLANES][fbc_pkg::COLS];
    logic [fbc_pkg::PLANES-1:0] r_live;
    logic [fbc_pkg::PLANES-1:0] n_live;

    logic                         r_v0, r_v1, r_v2;
    logic                         en0, en1, en2;

    logic                         r0_box;
    logic signed [COORD_BITS-1:0] r0_lo [fbc_pkg::AXES];
    logic signed [COORD_BITS-1:0] r0_hi [fbc_pkg::AXES];

    logic                         r1_box;
    logic signed [PW-1:0]         r1_max [fbc_pkg::PLANES][fbc_pkg::AXES];
    logic signed [PW-1:0]         n1_max [fbc_pkg::PLANES][fbc_pkg::AXES];

    logic                         r2_visible;
    logic                         n2_visible;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= fbc_pkg::ROW0_RST;
            r_mat[1] <= fbc_pkg::ROW1_RST;
            r_mat[2] <= fbc_pkg::ROW2_RST;
            r_mat[3] <= fbc_pkg::ROW3_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbc_pkg::CFG_ROW0: r_mat[0] <= i_cfg_data;
                fbc_pkg::CFG_ROW1: r_mat[1] <= i_cfg_data;
                fbc_pkg::CFG_ROW2: r_mat[2] <= i_cfg_data;
                fbc_pkg::CFG_ROW3: r_mat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // plane coefficients: row3 plus or minus rows 0..2
    always_comb begin
        logic signed [COEF_BITS-1:0] v_r3;
        logic signed [COEF_BITS-1:0] v_rn;
        for (int p = 0; p < fbc_pkg::PLANES; p++) begin
            for (int k = 0; k < fbc_pkg::COLS; k++) begin
                v_r3 = r_mat[3][fbc_pkg::LANE_W*k +: COEF_BITS];
                v_rn = r_mat[p/2][fbc_pkg::LANE_W*k +: COEF_BITS];
                if (fbc_pkg::PLANE_MINUS[p]) begin
                    n_coef[p][k] = CW'(v_r3) - CW'(v_rn);
                end else begin
                    n_coef[p][k] = CW'(v_r3) + CW'(v_rn);
                end
            end
            n_live[p] = (n_coef[p][0] != '0) || (n_coef[p][1] != '0) ||
                        (n_coef[p][2] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_live <= n_live;
    end

    // pipeline flow
    assign en2        = !r_v2 || i_out_ready;
    assign en1        = !r_v1 || en2;
    assign en0        = !r_v0 || en1;
    assign o_in_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_in_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage 0: input word
    always_ff @(posedge i_clk) begin
        if (en0 && i_in_valid) begin
            r0_box   <= i_volume_is_box;
            r0_lo[0] <= i_min_x;
            r0_lo[1] <= i_min_y;
            r0_lo[2] <= i_min_z;
            r0_hi[0] <= i_max_x;
            r0_hi[1] <= i_max_y;
            r0_hi[2] <= i_max_z;
        end
    end

    // stage 1: larger corner term per plane and axis
    always_comb begin
        logic signed [PW-1:0] v_plo;
        logic signed [PW-1:0] v_phi;
        for (int p = 0; p < fbc_pkg::PLANES; p++) begin
            for (int k = 0; k < fbc_pkg::AXES; k++) begin
                v_plo = PW'(r_coef[p][k]) * PW'(r0_lo[k]);
                v_phi = PW'(r_coef[p][k]) * PW'(r0_hi[k]);
                n1_max[p][k] = (v_plo > v_phi) ? v_plo : v_phi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && r_v0) begin
            r1_box <= r0_box;
            r1_max <= n1_max;
        end
    end

    // stage 2: best-corner dot product, reject on any live plane or a non-box volume
    always_comb begin
        logic signed [SW-1:0] v_sum;
        logic [fbc_pkg::PLANES-1:0] v_rej;
        for (int p = 0; p < fbc_pkg::PLANES; p++) begin
            v_sum = SW'(r_coef[p][3]) <<< fbc_pkg::W_SHIFT;
            for (int k = 0; k < fbc_pkg::AXES; k++) begin
                v_sum = v_sum + SW'(r1_max[p][k]);
            end
            v_rej[p] = r_live[p] && v_sum[SW-1];
        end
        n2_visible = r1_box && !(|v_rej);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r2_visible <= n2_visible;
        end
    end

    assign o_out_valid = r_v2;
    assign o_visible   = r2_visible;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v0 && r_v1 && r_v2 && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v0)
        else $error("accepted word missing from input stage");

    a_s1_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && !i_out_ready) |=> r_v1)
        else $error("middle stage dropped a word during stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== dv/tb_frustum_box_cull_top.sv =====
module tb_frustum_box_cull_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = fbc_pkg::COORD_BITS_DEF;
    localparam int HALF_NS    = 10;
    localparam int PIPE_DEPTH = 3;
    localparam int LONG_HOLD  = 64;
    localparam int PHASES     = 14;
    localparam int TIMEOUT_NS = 8_000_000;
    localparam longint W_ONE  = 16;

    // Plane p pairs row3 with row p/2; set bits subtract that row.
    localparam logic [fbc_pkg::PLANES-1:0] SUBTRACT_ROW = 6'b100110;

    localparam bit CHECKED   = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct {
        logic                      is_box;
        logic signed [COORD_W-1:0] lo [fbc_pkg::AXES];
        logic signed [COORD_W-1:0] hi [fbc_pkg::AXES];
    } t_box;

    typedef struct {
        t_box b;
        bit   typed;
        logic want;
    } t_probe;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [fbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [fbc_pkg::CFG_W-1:0]         i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic                              i_volume_is_box;
    logic signed [COORD_W-1:0]         i_min_x;
    logic signed [COORD_W-1:0]         i_min_y;
    logic signed [COORD_W-1:0]         i_min_z;
    logic signed [COORD_W-1:0]         i_max_x;
    logic signed [COORD_W-1:0]         i_max_y;
    logic signed [COORD_W-1:0]         i_max_z;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_visible;

    logic [fbc_pkg::CFG_W-1:0] cull_rows [fbc_pkg::ROWS];
    logic                      expected_visible [$];
    t_probe                    probe_tab [$];
    logic                      visible_want;
    bit                        hold_off_req;
    int                        mismatches;
    int                        words_out;

    frustum_box_cull_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_volume_is_box (i_volume_is_box),
        .i_min_x         (i_min_x),
        .i_min_y         (i_min_y),
        .i_min_z         (i_min_z),
        .i_max_x         (i_max_x),
        .i_max_y         (i_max_y),
        .i_max_z         (i_max_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_visible       (o_visible)
    );

    always begin
        i_clk = 1'b0;
        #(HALF_NS);
        i_clk = 1'b1;
        #(HALF_NS);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: word %0d: %s", $realtime, words_out, msg);
        mismatches++;
    endtask

    function automatic logic predict_visible(input t_box b);
        longint coef [fbc_pkg::COLS];
        longint best;
        longint r3;
        longint rn;
        if (!b.is_box) begin
            return 1'b0;
        end
        for (int p = 0; p < fbc_pkg::PLANES; p++) begin
            for (int k = 0; k < fbc_pkg::COLS; k++) begin
                r3 = longint'($signed(cull_rows[3][fbc_pkg::LANE_W*k +: fbc_pkg::LANE_W]));
                rn = longint'($signed(cull_rows[p/2][fbc_pkg::LANE_W*k +: fbc_pkg::LANE_W]));
                coef[k] = SUBTRACT_ROW[p] ? r3 - rn : r3 + rn;
            end
            if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0) begin
                continue;
            end
            best = coef[3] * W_ONE;
            for (int k = 0; k < fbc_pkg::AXES; k++) begin
                r3 = coef[k] * longint'(b.lo[k]);
                rn = coef[k] * longint'(b.hi[k]);
                best += (r3 > rn) ? r3 : rn;
            end
            if (best < 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_box random_box();
        t_box b;
        int   span;
        int   mid;
        int   half;
        logic signed [COORD_W-1:0] tmp;
        b.is_box = ($urandom_range(9) != 0);
        case ($urandom_range(3))
            0: span = 0;
            1: span = 48;
            2: span = 600;
            default: span = 9000;
        endcase
        for (int k = 0; k < fbc_pkg::AXES; k++) begin
            if (span == 0) begin
                b.lo[k] = COORD_W'($urandom);
                b.hi[k] = COORD_W'($urandom);
            end else begin
                mid     = int'($urandom_range(2 * span)) - span;
                half    = int'($urandom_range(span));
                b.lo[k] = COORD_W'(mid - half);
                b.hi[k] = COORD_W'(mid + half);
                if ($urandom_range(15) == 0) begin
                    tmp     = b.lo[k];
                    b.lo[k] = b.hi[k];
                    b.hi[k] = tmp;
                end
            end
        end
        return b;
    endfunction

    task automatic add_probe(input logic is_box, input int lx, input int ly, input int lz,
                             input int hx, input int hy, input int hz,
                             input bit typed, input logic want);
        t_probe pr;
        pr.b.is_box = is_box;
        pr.b.lo[0]  = COORD_W'(lx);
        pr.b.lo[1]  = COORD_W'(ly);
        pr.b.lo[2]  = COORD_W'(lz);
        pr.b.hi[0]  = COORD_W'(hx);
        pr.b.hi[1]  = COORD_W'(hy);
        pr.b.hi[2]  = COORD_W'(hz);
        pr.typed    = typed;
        pr.want     = want;
        probe_tab.push_back(pr);
    endtask

    task automatic offer(input t_box b, input bit typed, input logic want);
        i_in_valid      <= 1'b1;
        i_volume_is_box <= b.is_box;
        i_min_x         <= b.lo[0];
        i_min_y         <= b.lo[1];
        i_min_z         <= b.lo[2];
        i_max_x         <= b.hi[0];
        i_max_y         <= b.hi[1];
        i_max_z         <= b.hi[2];
        do @(posedge i_clk); while (!o_in_ready);
        expected_visible.push_back(typed ? want : predict_visible(b));
    endtask

    task automatic drain();
        while (expected_visible.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_matrix(input logic [fbc_pkg::CFG_W-1:0] m [fbc_pkg::ROWS]);
        drain();
        repeat (PIPE_DEPTH + 1) @(posedge i_clk);
        for (int r = 0; r < fbc_pkg::ROWS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= fbc_pkg::CFG_ROW0 + fbc_pkg::CFG_IDX_W'(r);
            i_cfg_data <= m[r];
            @(posedge i_clk);
            cull_rows[r] = m[r];
        end
        // unused index, must not land anywhere
        i_cfg_idx  <= fbc_pkg::CFG_IDX_W'($urandom_range((1 << fbc_pkg::CFG_IDX_W) - 1,
                                                         int'(fbc_pkg::CFG_ROW3) + 1));
        i_cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (PIPE_DEPTH + 1) @(posedge i_clk);
    endtask

    task automatic send_phase(input int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < count; n++) begin
            offer(random_box(), PREDICTED, 1'b0);
            if (n == count - 1) begin
                break;
            end
            burst_left--;
            if ($urandom_range(39) == 0) begin
                i_in_valid <= 1'b0;
                drain();
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 8);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
        drain();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_visible.size() == 0) begin
                report_mismatch($sformatf("unexpected word, visible=%0b", o_visible));
            end else begin
                visible_want = expected_visible.pop_front();
                if (o_visible !== visible_want) begin
                    report_mismatch($sformatf("visible=%0b, want %0b", o_visible, visible_want));
                end
            end
            words_out++;
        end
    end

    initial begin : out_side
        int seg_mode;
        int seg_len;
        i_out_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            seg_mode = $urandom_range(4);
            seg_len  = $urandom_range(1, 40);
            for (int t = 0; t < seg_len; t++) begin
                case (seg_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(1));
                    2: i_out_ready <= (t % 3 == 2);
                    3: i_out_ready <= ($urandom_range(7) != 0);
                    default: i_out_ready <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : in_side
        logic [fbc_pkg::CFG_W-1:0] m [fbc_pkg::ROWS];
        int n_items;
        int s;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_volume_is_box = 1'b0;
        i_min_x         = '0;
        i_min_y         = '0;
        i_min_z         = '0;
        i_max_x         = '0;
        i_max_y         = '0;
        i_max_z         = '0;
        cull_rows       = '{fbc_pkg::ROW0_RST, fbc_pkg::ROW1_RST,
                            fbc_pkg::ROW2_RST, fbc_pkg::ROW3_RST};

        // identity matrix: visible region is the cube of +-1.0 (16 raw)
        add_probe(1'b0, 0, 0, 0, 0, 0, 0, CHECKED, 1'b0);
        add_probe(1'b0, -16, -16, -16, 16, 16, 16, CHECKED, 1'b0);
        add_probe(1'b0, -1, -1, -1, -1, -1, -1, CHECKED, 1'b0);
        add_probe(1'b1, 0, 0, 0, 0, 0, 0, CHECKED, 1'b1);
        add_probe(1'b1, -16, -16, -16, 16, 16, 16, CHECKED, 1'b1);
        add_probe(1'b1, -32768, -32768, -32768, 32767, 32767, 32767, CHECKED, 1'b1);
        add_probe(1'b1, -32768, -32768, -32768, -32768, -32768, -32768, CHECKED, 1'b0);
        add_probe(1'b1, 32767, 32767, 32767, 32767, 32767, 32767, CHECKED, 1'b0);
        add_probe(1'b1, -32768, 0, 0, -17, 0, 0, CHECKED, 1'b0);
        add_probe(1'b1, -32768, 0, 0, -16, 0, 0, CHECKED, 1'b1);
        add_probe(1'b1, 17, 0, 0, 32767, 0, 0, CHECKED, 1'b0);
        add_probe(1'b1, 16, 0, 0, 32767, 0, 0, CHECKED, 1'b1);
        add_probe(1'b1, 0, 17, 0, 0, 100, 0, CHECKED, 1'b0);
        add_probe(1'b1, 0, -100, 0, 0, -17, 0, CHECKED, 1'b0);
        add_probe(1'b1, 0, 0, -100, 0, 0, -17, CHECKED, 1'b0);
        add_probe(1'b1, 0, 0, 17, 0, 0, 32767, CHECKED, 1'b0);
        add_probe(1'b1, 32767, 32767, 32767, -32768, -32768, -32768, CHECKED, 1'b1);
        add_probe(1'b1, 100, 0, 0, 50, 0, 0, CHECKED, 1'b0);
        add_probe(1'b1, -21846, -21846, -21846, 21845, 21845, 21845, PREDICTED, 1'b0);
        add_probe(1'b1, 21845, -21846, 21845, -21846, 21845, -21846, PREDICTED, 1'b0);
        add_probe(1'b1, -1, -1, -1, -1, -1, -1, PREDICTED, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_tab[i]) begin
            offer(probe_tab[i].b, probe_tab[i].typed, probe_tab[i].want);
        end
        i_in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < fbc_pkg::ROWS; r++) begin
                m[r] = '0;
            end
            case (ph)
                0: begin
                    for (int r = 0; r < fbc_pkg::ROWS; r++) begin
                        m[r][fbc_pkg::LANE_W*r +: fbc_pkg::LANE_W] = 16'h1000;
                    end
                    n_items = 60;
                end
                1: n_items = 20;
                2: begin
                    // all normals zero, negative offset: nothing rejects
                    m[3][fbc_pkg::LANE_W*3 +: fbc_pkg::LANE_W] = 16'h8000;
                    n_items = 20;
                end
                3: begin
                    m = '{{4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}};
                    n_items = 25;
                end
                4: begin
                    m = '{{4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}};
                    n_items = 25;
                end
                5: begin
                    m = '{{4{16'hffff}}, {4{16'hffff}}, {4{16'hffff}}, {4{16'hffff}}};
                    n_items = 20;
                end
                10, 11: begin
                    m[0][0 +: fbc_pkg::LANE_W] =
                        fbc_pkg::LANE_W'($urandom_range(2048, 12000));
                    m[1][fbc_pkg::LANE_W +: fbc_pkg::LANE_W] =
                        fbc_pkg::LANE_W'($urandom_range(2048, 12000));
                    m[2][fbc_pkg::LANE_W*2 +: fbc_pkg::LANE_W] =
                        fbc_pkg::LANE_W'(-int'($urandom_range(4096, 6000)));
                    m[2][fbc_pkg::LANE_W*3 +: fbc_pkg::LANE_W] =
                        fbc_pkg::LANE_W'(-int'($urandom_range(1000, 20000)));
                    m[3][fbc_pkg::LANE_W*2 +: fbc_pkg::LANE_W] = 16'hf000;
                    n_items = 50;
                end
                12, 13: begin
                    for (int r = 0; r < fbc_pkg::ROWS; r++) begin
                        m[r] = {$urandom, $urandom};
                    end
                    n_items = 30;
                end
                default: begin
                    // scale plus translation
                    for (int r = 0; r < fbc_pkg::AXES; r++) begin
                        s = $urandom_range(256, 16384);
                        if ($urandom_range(1) != 0) begin
                            s = -s;
                        end
                        m[r][fbc_pkg::LANE_W*r +: fbc_pkg::LANE_W] = fbc_pkg::LANE_W'(s);
                        m[r][fbc_pkg::LANE_W*3 +: fbc_pkg::LANE_W] =
                            fbc_pkg::LANE_W'(int'($urandom_range(8191)) - 4096);
                    end
                    m[3][fbc_pkg::LANE_W*3 +: fbc_pkg::LANE_W] =
                        fbc_pkg::LANE_W'($urandom_range(1024, 16384));
                    n_items = 50;
                end
            endcase
            load_matrix(m);
            if (ph == 0 || ph == 6) begin
                hold_off_req = 1'b1;
            end
            send_phase(n_items);
        end

        drain();
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
